@@ design/imu_gravity_removal_filter_macros.svh @@
// Assertion macros for the gravity removal filter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef IMU_GRAVITY_REMOVAL_FILTER_MACROS_SVH
`define IMU_GRAVITY_REMOVAL_FILTER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define IGR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define IGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/igr_pkg.sv @@
// Shared constants and types for the gravity removal filter.
// No dependencies; used by every module of the block.
`default_nettype none

package igr_pkg;

  // Field and arithmetic widths
  localparam int SAMPLE_BITS     = 16;
  localparam int CAL_SAMPLES_DEF = 100;
  localparam int CNT_W           = 8;
  localparam int FRAC_BITS       = 16;
  localparam int WGT_W           = 16;
  localparam int SUM_W           = SAMPLE_BITS + CNT_W;
  localparam int AVG_W           = SAMPLE_BITS + FRAC_BITS;
  localparam int REM_W           = CNT_W + 1;
  localparam int OUT_W           = SAMPLE_BITS + 1;
  localparam int DIFF_W          = SAMPLE_BITS + 2;

  // Calibration divide: load, quotient, remainder, fraction, seed
  localparam int DIV_CYCLES      = 5;
  localparam int DCNT_W          = $clog2(DIV_CYCLES);

  // Register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_EMA_WEIGHT = '0;
  localparam logic [WGT_W-1:0]  EMA_WEIGHT_RST = 16'd3277;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic accum;     // add sample into calibration sum
    logic div_load;  // load divider from sum magnitude
    logic div_quot;  // whole quotient by reciprocal multiply
    logic div_rem;   // remainder, scaled for the fraction
    logic div_frac;  // fraction bits by reciprocal multiply
    logic div_done;  // latch gravity and average seed
    logic filt;      // moving average update
  } ctrl_t;

endpackage

`default_nettype wire

@@ design/imu_gravity_removal_filter.sv @@
// Gravity removal filter top level: register port, sequencer, three lanes, merge.
// Depends on igr_pkg, igr_lane and igr_merge.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one three-axis sample word.
//   Output channel (out_valid/out_stall) gives one vehicle-frame word.
//   After reset the first CAL_SAMPLES words (100 by default) are summed per
//   axis and give no output. The word that completes the count starts a
//   short divide by reciprocal multiplication (load, quotient, remainder,
//   fraction, seed) that holds in_stall high throughout; it yields the
//   gravity vector and seeds the moving average. Every later word updates
//   the average (one multiply-add per axis in the accept cycle) and gives one
//   output word via the average and output registers. Throughput is one word per
//   cycle unless stalled, set by the per-axis multiply-add loop on the average
//   register. When the receiver stalls, the output word holds and one more word
//   can be accepted into the internal stage; then in_stall rises until the
//   output drains. Reset clears the calibration count, sums and flags and sets
//   ema_weight to 3277. ema_weight is written through the APB port (address 0).
`default_nettype none

module imu_gravity_removal_filter #(
  parameter int CAL_SAMPLES = igr_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // sample channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [igr_pkg::SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [igr_pkg::SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [igr_pkg::SAMPLE_BITS-1:0] in_sample_z,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [igr_pkg::OUT_W-1:0]            out_vehicle_accel_x,
  output logic signed [igr_pkg::OUT_W-1:0]            out_vehicle_accel_y,
  output logic signed [igr_pkg::OUT_W-1:0]            out_vehicle_accel_z,
  // register port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [igr_pkg::ADDR_W-1:0]             paddr,
  input  wire logic [igr_pkg::DATA_W-1:0]             pwdata,
  output logic [igr_pkg::DATA_W-1:0]                  prdata,
  output logic                                        pready
);

  localparam int CNT_W  = igr_pkg::CNT_W;
  localparam int DCNT_W = igr_pkg::DCNT_W;
  localparam int WGT_W  = igr_pkg::WGT_W;
  localparam int DW     = igr_pkg::DIFF_W;
  localparam int AW     = igr_pkg::ADDR_W;

  localparam logic [CNT_W:0]    CAL_LAST = (CNT_W+1)'(CAL_SAMPLES);

  // Divide step codes
  localparam logic [DCNT_W-1:0] DIV_LOAD = DCNT_W'(0);
  localparam logic [DCNT_W-1:0] DIV_QUOT = DCNT_W'(1);
  localparam logic [DCNT_W-1:0] DIV_REM  = DCNT_W'(2);
  localparam logic [DCNT_W-1:0] DIV_FRAC = DCNT_W'(3);
  localparam logic [DCNT_W-1:0] DIV_DONE = DCNT_W'(igr_pkg::DIV_CYCLES - 1);

  typedef enum logic [2:0] {
    ST_CAL = 3'b001,
    ST_DIV = 3'b010,
    ST_RUN = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                a_valid_r, a_valid_nxt;
  logic [WGT_W-1:0]    weight_r, weight_nxt;

  igr_pkg::ctrl_t      ctrl;
  logic                accept;
  logic                a_take;
  logic                reg_wr;
  logic [AW-3:0]       reg_idx;
  logic signed [DW-1:0] lane_d [3];
  logic signed [igr_pkg::SAMPLE_BITS-1:0] lane_s [3];

  // Register port
  always_comb begin
    reg_idx    = paddr[AW-1:2];
    reg_wr     = psel && penable && pwrite && (reg_idx == igr_pkg::REG_EMA_WEIGHT);
    weight_nxt = reg_wr ? pwdata[WGT_W-1:0] : weight_r;
    pready     = 1'b1;
    prdata     = (reg_idx == igr_pkg::REG_EMA_WEIGHT) ?
                 {{(igr_pkg::DATA_W-WGT_W){1'b0}}, weight_r} : '0;
  end

  // Sequencer: calibrate, divide, then filter
  always_comb begin
    in_stall    = (state_r == ST_DIV) || (a_valid_r && out_valid && out_stall);
    accept      = in_valid && !in_stall;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    dcnt_nxt    = dcnt_r;
    ctrl        = '0;
    case (state_r)
      ST_CAL: begin
        ctrl.accum = accept;
        if (accept) begin
          cnt_nxt = cnt_r + 1'b1;
          if (({1'b0, cnt_r} + 1'b1) >= CAL_LAST) begin
            state_nxt = ST_DIV;
            dcnt_nxt  = DIV_LOAD;
          end
        end
      end
      ST_DIV: begin
        dcnt_nxt      = dcnt_r + 1'b1;
        ctrl.div_load = (dcnt_r == DIV_LOAD);
        ctrl.div_quot = (dcnt_r == DIV_QUOT);
        ctrl.div_rem  = (dcnt_r == DIV_REM);
        ctrl.div_frac = (dcnt_r == DIV_FRAC);
        ctrl.div_done = (dcnt_r == DIV_DONE);
        if (dcnt_r == DIV_DONE) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.filt = accept;
      end
      default: begin
        state_nxt = ST_CAL;
      end
    endcase
    // Stage between the average registers and the output word
    a_valid_nxt = ctrl.filt ? 1'b1 : (a_take ? 1'b0 : a_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CAL;
      cnt_r     <= '0;
      dcnt_r    <= '0;
      a_valid_r <= 1'b0;
      weight_r  <= igr_pkg::EMA_WEIGHT_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      dcnt_r    <= dcnt_nxt;
      a_valid_r <= a_valid_nxt;
      weight_r  <= weight_nxt;
    end
  end

  // Axis lanes
  assign lane_s[0] = in_sample_x;
  assign lane_s[1] = in_sample_y;
  assign lane_s[2] = in_sample_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    igr_lane #(
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sample    (lane_s[g]),
      .weight    (weight_r),
      .grav_diff (lane_d[g])
    );
  end

  // Frame mapping and output word
  igr_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .a_valid             (a_valid_r),
    .d_x                 (lane_d[0]),
    .d_y                 (lane_d[1]),
    .d_z                 (lane_d[2]),
    .a_take              (a_take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_vehicle_accel_x (out_vehicle_accel_x),
    .out_vehicle_accel_y (out_vehicle_accel_y),
    .out_vehicle_accel_z (out_vehicle_accel_z)
  );

endmodule

`default_nettype wire

@@ design/igr_lane.sv @@
// One axis lane: calibration sum, reciprocal-multiply divider, moving average.
// Depends on igr_pkg.
`default_nettype none

module igr_lane #(
  parameter int CAL_SAMPLES = igr_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire igr_pkg::ctrl_t                        ctrl,
  input  wire logic signed [igr_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [igr_pkg::WGT_W-1:0]             weight,
  output logic signed [igr_pkg::DIFF_W-1:0]          grav_diff
);

  localparam int SB     = igr_pkg::SAMPLE_BITS;
  localparam int FB     = igr_pkg::FRAC_BITS;
  localparam int SUM_W  = igr_pkg::SUM_W;
  localparam int AVG_W  = igr_pkg::AVG_W;
  localparam int REM_W  = igr_pkg::REM_W;
  localparam int CNT_W  = igr_pkg::CNT_W;
  localparam int WGT_W  = igr_pkg::WGT_W;
  localparam int PROD_W = AVG_W + WGT_W + 2;
  localparam int DS_W   = AVG_W + 2;
  // Dividend holds the sum magnitude, then remainder << FB plus half divisor
  localparam int DV_W   = SUM_W;
  // Reciprocal shift: exact floor for dividends below 2^DV_W, divisor below 2^CNT_W
  localparam int RSH    = DV_W + CNT_W;

  localparam logic [REM_W-1:0]         DIVISOR  = REM_W'(CAL_SAMPLES);
  localparam logic [DV_W-1:0]          DIV_D    = DV_W'(CAL_SAMPLES);
  localparam logic [DV_W-1:0]          HALF_DIV = DV_W'(CAL_SAMPLES / 2);
  localparam logic [RSH:0]             RECIP    =
    (RSH+1)'(((64'd1 << RSH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic signed [PROD_W-1:0] HALF_P   = PROD_W'(1) << (FB - 1);
  localparam logic signed [DS_W-1:0]   HALF_D   = DS_W'(1) << (FB - 1);

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DV_W-1:0]          dv_r, dv_nxt;
  logic [DV_W-1:0]          q_r, q_nxt;
  logic                     rb_r, rb_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [AVG_W-1:0]  avg_r, avg_nxt;
  logic signed [SB-1:0]     grav_r, grav_nxt;

  logic [SUM_W-1:0]         mag;
  logic [DV_W+RSH:0]        prod_q;
  logic [DV_W-1:0]          quo;
  logic [DV_W-1:0]          rem;
  logic                     round_up;
  logic [AVG_W-1:0]         seed_mag;
  logic [DV_W-1:0]          grav_mag;
  logic signed [AVG_W:0]    diff;
  logic signed [WGT_W:0]    wgt_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] upd;
  logic signed [DS_W-1:0]   dsum;

  // Divider datapath: quotient by reciprocal, remainder, then fraction the same way
  always_comb begin
    mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    prod_q   = dv_r * RECIP;
    quo      = prod_q[RSH +: DV_W];
    rem      = dv_r - q_r * DIV_D;
    round_up = ({rem[REM_W-2:0], 1'b0} >= DIVISOR);
    seed_mag = {q_r[AVG_W-FB-1:0], dv_r[FB-1:0]};
    grav_mag = q_r + DV_W'(rb_r);
  end

  // Moving average update: avg += round((s<<16 - avg) * w >> 16)
  always_comb begin
    diff  = {{1{sample[SB-1]}}, sample, {FB{1'b0}}} - {avg_r[AVG_W-1], avg_r};
    wgt_s = {1'b0, weight};
    prod  = diff * wgt_s;
    upd   = (prod + HALF_P) >>> FB;
  end

  // Smoothed value less gravity, rounded to whole units
  always_comb begin
    dsum = {{2{avg_r[AVG_W-1]}}, avg_r}
         - ({{(DS_W-SB){grav_r[SB-1]}}, grav_r} <<< FB) + HALF_D;
    grav_diff = dsum[FB +: igr_pkg::DIFF_W];
  end

  // Next-state selection
  always_comb begin
    sum_nxt  = sum_r;
    dv_nxt   = dv_r;
    q_nxt    = q_r;
    rb_nxt   = rb_r;
    neg_nxt  = neg_r;
    avg_nxt  = avg_r;
    grav_nxt = grav_r;
    if (ctrl.accum) begin
      sum_nxt = sum_r + {{(SUM_W-SB){sample[SB-1]}}, sample};
    end
    if (ctrl.div_load) begin
      dv_nxt  = mag;
      neg_nxt = sum_r[SUM_W-1];
    end
    if (ctrl.div_quot) begin
      q_nxt = quo;
    end
    if (ctrl.div_rem) begin
      dv_nxt = DV_W'({rem[CNT_W-1:0], {FB{1'b0}}}) + HALF_DIV;
      rb_nxt = round_up;
    end
    if (ctrl.div_frac) begin
      dv_nxt = quo;
    end
    if (ctrl.div_done) begin
      avg_nxt  = neg_r ? -$signed(seed_mag) : $signed(seed_mag);
      grav_nxt = neg_r ? -$signed(grav_mag[SB-1:0]) : $signed(grav_mag[SB-1:0]);
    end
    if (ctrl.filt) begin
      avg_nxt = avg_r + $signed(upd[AVG_W-1:0]);
    end
  end

  // Calibration sum is control-like state and is cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // Datapath registers, written before first use
  always_ff @(posedge clk) begin
    dv_r   <= dv_nxt;
    q_r    <= q_nxt;
    rb_r   <= rb_nxt;
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
    grav_r <= grav_nxt;
  end

endmodule

`default_nettype wire

@@ design/igr_merge.sv @@
// Merge stage: maps the three lane results to the vehicle frame,
// negates and saturates them, and holds the output word. Depends on igr_pkg.
`default_nettype none

module igr_merge (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              a_valid,
  input  wire logic signed [igr_pkg::DIFF_W-1:0] d_x,
  input  wire logic signed [igr_pkg::DIFF_W-1:0] d_y,
  input  wire logic signed [igr_pkg::DIFF_W-1:0] d_z,
  output logic                                   a_take,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [igr_pkg::OUT_W-1:0]       out_vehicle_accel_x,
  output logic signed [igr_pkg::OUT_W-1:0]       out_vehicle_accel_y,
  output logic signed [igr_pkg::OUT_W-1:0]       out_vehicle_accel_z
);

  localparam int DW = igr_pkg::DIFF_W;
  localparam int OW = igr_pkg::OUT_W;
  localparam logic signed [DW:0] SAT_HI = (DW+1)'((1 << (OW - 1)) - 1);
  localparam logic signed [DW:0] SAT_LO = -(DW+1)'(1 << (OW - 1));

  logic                 out_valid_r, out_valid_nxt;
  logic signed [OW-1:0] vx_r, vy_r, vz_r;

  // Negate and clamp to the output range
  function automatic logic signed [OW-1:0] neg_sat(input logic signed [DW-1:0] d);
    logic signed [DW:0] n;
    n = -{d[DW-1], d};
    if (n > SAT_HI) begin
      neg_sat = SAT_HI[OW-1:0];
    end else if (n < SAT_LO) begin
      neg_sat = SAT_LO[OW-1:0];
    end else begin
      neg_sat = n[OW-1:0];
    end
  endfunction

  // Output register is loaded when empty or being drained
  always_comb begin
    a_take        = a_valid && (!out_valid_r || !out_stall);
    out_valid_nxt = a_take ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Vehicle frame: x from -y, y from -x, z from -z
  always_ff @(posedge clk) begin
    if (a_take) begin
      vx_r <= neg_sat(d_y);
      vy_r <= neg_sat(d_x);
      vz_r <= neg_sat(d_z);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vehicle_accel_x = vx_r;
  assign out_vehicle_accel_y = vy_r;
  assign out_vehicle_accel_z = vz_r;

endmodule

`default_nettype wire

@@ design/igr_checker.sv @@
// Port-level checker for the gravity removal filter, bound to the top level.
// Depends on igr_pkg and imu_gravity_removal_filter_macros.svh.
`default_nettype none

`include "imu_gravity_removal_filter_macros.svh"

module igr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [igr_pkg::OUT_W-1:0]   out_vehicle_accel_x,
  input wire logic signed [igr_pkg::OUT_W-1:0]   out_vehicle_accel_y,
  input wire logic signed [igr_pkg::OUT_W-1:0]   out_vehicle_accel_z
);

  // A stalled output word holds
  `IGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_vehicle_accel_x) && $stable(out_vehicle_accel_y) && $stable(out_vehicle_accel_z), "stalled output word changed")

  // A new output word follows an accepted input word through the average and output registers
  `IGR_ASSERT_SAME(a_out_latency, $rose(out_valid), $past(in_valid && !in_stall, 2), "output word without input two cycles earlier")

  // Only one word fits behind a stalled output
  `IGR_ASSERT_SAME(a_skid_full, out_stall && $past(out_valid && out_stall && in_valid && !in_stall), in_stall, "input accepted with internal stage full")

endmodule

bind imu_gravity_removal_filter igr_checker u_igr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_vehicle_accel_x (out_vehicle_accel_x),
  .out_vehicle_accel_y (out_vehicle_accel_y),
  .out_vehicle_accel_z (out_vehicle_accel_z)
);

`default_nettype wire
